// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tracker assertion failed");

// Next-cycle implication, checked out of reset.
`define MAT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tracker assertion failed");

`endif

// File: rtl/mat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_pkg
// Command, status, search and cell operation codes and the shared structs.
// ----------------------------------------------------------------------------
package mat_pkg;

    localparam int PID_W  = 32;
    localparam int TIME_W = 48;
    localparam int OUT_LIMIT = 16;

    // Command codes.
    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_REMOVE  = 3'd1;
    localparam logic [2:0] CMD_SENT    = 3'd2;
    localparam logic [2:0] CMD_ACK     = 3'd3;
    localparam logic [2:0] CMD_TIMEOUT = 3'd4;
    localparam logic [2:0] CMD_OLDEST  = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_BADSLOT = 2'd3;

    // Search modes of the cell chain.
    localparam logic [1:0] MD_FREE  = 2'd0;
    localparam logic [1:0] MD_MATCH = 2'd1;
    localparam logic [1:0] MD_MIN   = 2'd2;

    // Cell operations.
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_CLRBIT  = 3'd2;
    localparam logic [2:0] OP_SEEN    = 3'd3;
    localparam logic [2:0] OP_CLRSEEN = 3'd4;

    localparam logic [TIME_W-1:0] TIME_ONES = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] TP_RESET  = 48'd1000000;

    typedef struct packed {
        logic [1:0]       mode;
        logic [PID_W-1:0] key;
    } t_mat_ctl;

    typedef struct packed {
        logic [2:0]        code;
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] stime;
    } t_mat_op;

    typedef struct packed {
        logic              found;
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] stime;
    } t_mat_cand;

    typedef struct packed {
        logic [1:0]        status;
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] stime;
        logic              released;
        logic              valid;
    } t_mat_res;

endpackage

// File: rtl/mat_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_cell
// One table entry plus one stage of the search chain that runs through all
// entries, carrying the best candidate found so far to the next cell.
// ----------------------------------------------------------------------------
module mat_cell #(
    parameter int TABLE_ENTRIES    = 16,
    parameter int SUBSCRIBER_SLOTS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mat_pkg::t_mat_ctl                    i_ctl,
    input  logic [SUBSCRIBER_SLOTS-1:0]          i_bit,
    input  mat_pkg::t_mat_op                     i_op,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]     i_op_idx,
    input  logic [SUBSCRIBER_SLOTS-1:0]          i_op_mask,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]     i_idx,
    input  mat_pkg::t_mat_cand                   i_cand,
    input  logic [SUBSCRIBER_SLOTS-1:0]          i_cmask,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]     i_cidx,
    output mat_pkg::t_mat_cand                   o_cand,
    output logic [SUBSCRIBER_SLOTS-1:0]          o_cmask,
    output logic [$clog2(TABLE_ENTRIES)-1:0]     o_cidx
);
    import mat_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic                        r_used;
    logic                        r_seen;
    logic [PID_W-1:0]            r_pid;
    logic [TIME_W-1:0]           r_time;
    logic [SUBSCRIBER_SLOTS-1:0] r_mask;
    t_mat_cand                   r_cand;
    logic [SUBSCRIBER_SLOTS-1:0] r_cmask;
    logic [IW-1:0]               r_cidx;
    logic                        w_hit;
    logic                        w_self_ok;
    logic                        w_take;
    logic [SUBSCRIBER_SLOTS-1:0] w_left;

    assign w_hit  = (i_op_idx == i_idx);
    assign w_left = r_mask & ~i_bit;

    // Does this entry qualify for the running search?
    always_comb begin
        unique case (i_ctl.mode)
            MD_FREE:  w_self_ok = !r_used;
            MD_MATCH: w_self_ok = r_used && (|(r_mask & i_bit)) && (r_pid == i_ctl.key);
            MD_MIN:   w_self_ok = r_used && (|(r_mask & i_bit)) && !r_seen;
            default:  w_self_ok = 1'b0;
        endcase
    end

    // Lower index wins, except that the minimum search prefers a strictly lower id.
    assign w_take = w_self_ok &&
                    (!i_cand.found || ((i_ctl.mode == MD_MIN) && (r_pid < i_cand.pid)));

    // Entry control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_seen <= 1'b0;
        end else begin
            unique case (i_op.code)
                OP_WRITE:   if (w_hit) r_used <= 1'b1;
                OP_CLRBIT:  if (w_hit && (w_left == '0)) r_used <= 1'b0;
                OP_SEEN:    if (w_hit) r_seen <= 1'b1;
                OP_CLRSEEN: r_seen <= 1'b0;
                default:    ;
            endcase
        end
    end

    // Entry payload.
    always_ff @(posedge i_clk) begin
        if (w_hit && (i_op.code == OP_WRITE)) begin
            r_pid  <= i_op.pid;
            r_time <= i_op.stime;
            r_mask <= i_op_mask;
        end else if (w_hit && (i_op.code == OP_CLRBIT)) begin
            r_mask <= w_left;
        end
    end

    // Chain stage toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.found <= 1'b0;
        end else begin
            r_cand.found <= w_take ? 1'b1 : i_cand.found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cand.pid   <= r_pid;
            r_cand.stime <= r_time;
            r_cmask      <= r_mask;
            r_cidx       <= i_idx;
        end else begin
            r_cand.pid   <= i_cand.pid;
            r_cand.stime <= i_cand.stime;
            r_cmask      <= i_cmask;
            r_cidx       <= i_cidx;
        end
    end

    assign o_cand  = r_cand;
    assign o_cmask = r_cmask;
    assign o_cidx  = r_cidx;

endmodule

// File: rtl/multicast_ack_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicast_ack_tracker
// Sender-side acknowledgement tracker for reliable multicast.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low. Results leave on
// the o_ result ports, one per cycle at most, each marked by o_strobe for one
// cycle; o_last flags the final result of the command. The receiver cannot
// stall, so results are never held back. The timeout period sits at APB byte
// address 0 (64-bit data, low 48 bits used); pready is always high.
// Every table search runs through the chain of TABLE_ENTRIES cells, one cell
// per cycle. Add and the untracked send cases run no search; send and ack run
// one. Remove and the timed-out list run one search per entry handled and one
// more that ends the command. The oldest query runs one search per subscriber
// slot. One command is handled at a time. Reset empties the table, deactivates
// all subscribers and sets the timeout period to 1000000.
// ----------------------------------------------------------------------------
module multicast_ack_tracker #(
    parameter int TABLE_ENTRIES    = 16,
    parameter int SUBSCRIBER_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [2:0]  i_sub_slot,
    input  logic [31:0] i_packet_id,
    input  logic [47:0] i_time_now,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_pid,
    output logic [47:0] o_out_time,
    output logic        o_released,
    output logic        o_valid_res,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import mat_pkg::*;

    localparam int N  = TABLE_ENTRIES;
    localparam int S  = SUBSCRIBER_SLOTS;
    localparam int IW = $clog2(N);
    localparam int SW = (S > 1) ? $clog2(S) : 1;
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_EVAL   = 2'd2;
    localparam logic [1:0] S_FIN    = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [IW-1:0]     r_cnt, n_cnt;
    logic [2:0]        r_cmd, n_cmd;
    logic [PID_W-1:0]  r_pid, n_pid;
    logic [TIME_W-1:0] r_now, n_now;
    logic [S-1:0]      r_bit, n_bit;
    logic [S-1:0]      r_active, n_active;
    logic [SW-1:0]     r_sc, n_sc;
    logic              r_found, n_found;
    logic [TIME_W-1:0] r_old, n_old;
    logic              r_hold_v, n_hold_v;
    t_mat_res          r_hold, n_hold;
    logic [4:0]        r_nres, n_nres;
    logic [TIME_W-1:0] r_tp;
    logic [1:0]        r_mode, n_mode;
    logic              r_strobe, n_strobe;
    logic              r_last, n_last;
    t_mat_res          r_out, n_out;

    t_mat_op           w_op;
    logic [IW-1:0]     w_op_idx;
    logic [S-1:0]      w_op_mask;
    logic              w_gen;
    t_mat_res          w_res;
    t_mat_ctl          w_ctl;
    logic [S-1:0]      w_slot_bit;
    logic              w_slot_ok;
    logic              w_slot_act;
    logic              w_late;
    logic              w_cfg_wr;

    t_mat_cand         w_cand  [N+1];
    logic [S-1:0]      w_cmask [N+1];
    logic [IW-1:0]     w_cidx  [N+1];

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[3] == 1'b0);
    assign prdata   = (paddr[3] == 1'b0) ? {16'd0, r_tp} : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp <= TP_RESET;
        end else if (w_cfg_wr) begin
            r_tp <= pwdata[TIME_W-1:0];
        end
    end

    // Cell chain.
    assign w_ctl.mode = r_mode;
    assign w_ctl.key  = r_pid;
    assign w_cand[0]  = '0;
    assign w_cmask[0] = '0;
    assign w_cidx[0]  = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        mat_cell #(
            .TABLE_ENTRIES    (N),
            .SUBSCRIBER_SLOTS (S)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_bit     (r_bit),
            .i_op      (w_op),
            .i_op_idx  (w_op_idx),
            .i_op_mask (w_op_mask),
            .i_idx     (IW'(g)),
            .i_cand    (w_cand[g]),
            .i_cmask   (w_cmask[g]),
            .i_cidx    (w_cidx[g]),
            .o_cand    (w_cand[g+1]),
            .o_cmask   (w_cmask[g+1]),
            .o_cidx    (w_cidx[g+1])
        );
    end

    // Slot decode of the incoming command.
    assign w_slot_ok  = (32'(i_sub_slot) < S);
    assign w_slot_bit = w_slot_ok ? ({{(S-1){1'b0}}, 1'b1} << i_sub_slot) : '0;
    assign w_slot_act = |(r_active & w_slot_bit);
    assign w_late     = ({1'b0, w_cand[N].stime} + {1'b0, r_tp}) <= {1'b0, r_now};

    // Command sequencer.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        n_pid    = r_pid;
        n_now    = r_now;
        n_bit    = r_bit;
        n_active = r_active;
        n_sc     = r_sc;
        n_found  = r_found;
        n_old    = r_old;
        n_mode   = r_mode;
        w_op     = '0;
        w_op_idx = w_cidx[N];
        w_op_mask = r_active;
        w_gen    = 1'b0;
        w_res    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_pid    = i_packet_id;
                    n_now    = i_time_now;
                    n_bit    = w_slot_bit;
                    n_cnt    = '0;
                    w_op.code = OP_CLRSEEN;
                    n_state  = S_SEARCH;
                    unique case (i_cmd)
                        CMD_ADD: begin
                            w_gen   = 1'b1;
                            n_state = S_FIN;
                            if (!w_slot_ok || w_slot_act) begin
                                w_res.status = ST_BADSLOT;
                            end else begin
                                n_active = r_active | w_slot_bit;
                            end
                        end
                        CMD_REMOVE, CMD_ACK, CMD_TIMEOUT: begin
                            n_mode = (i_cmd == CMD_ACK) ? MD_MATCH : MD_MIN;
                            if (!w_slot_act) begin
                                w_gen        = 1'b1;
                                w_res.status = ST_BADSLOT;
                                n_state      = S_FIN;
                            end
                        end
                        CMD_SENT: begin
                            n_mode = MD_FREE;
                            if (i_packet_id == '0) begin
                                w_gen   = 1'b1;
                                n_state = S_FIN;
                            end else if (r_active == '0) begin
                                w_gen          = 1'b1;
                                w_res.pid      = i_packet_id;
                                w_res.stime    = i_time_now;
                                w_res.released = 1'b1;
                                w_res.valid    = 1'b1;
                                n_state        = S_FIN;
                            end
                        end
                        CMD_OLDEST: begin
                            n_mode  = MD_MIN;
                            n_sc    = '0;
                            n_found = 1'b0;
                            n_old   = TIME_ONES;
                            n_bit   = {{(S-1){1'b0}}, 1'b1};
                        end
                        default: begin
                            w_gen   = 1'b1;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IW'(N - 1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_cnt   = '0;
                n_state = S_FIN;
                unique case (r_cmd)
                    CMD_REMOVE: begin
                        if (w_cand[N].found) begin
                            w_op.code = OP_CLRBIT;
                            n_state   = S_SEARCH;
                            if ((w_cmask[N] & ~r_bit) == '0) begin
                                w_gen          = 1'b1;
                                w_res.pid      = w_cand[N].pid;
                                w_res.stime    = w_cand[N].stime;
                                w_res.released = 1'b1;
                                w_res.valid    = 1'b1;
                            end
                        end else begin
                            n_active = r_active & ~r_bit;
                        end
                    end
                    CMD_ACK: begin
                        w_gen = 1'b1;
                        if (w_cand[N].found) begin
                            w_op.code      = OP_CLRBIT;
                            w_res.pid      = w_cand[N].pid;
                            w_res.stime    = w_cand[N].stime;
                            w_res.released = ((w_cmask[N] & ~r_bit) == '0);
                            w_res.valid    = 1'b1;
                        end else begin
                            w_res.status = ST_NOMATCH;
                        end
                    end
                    CMD_TIMEOUT: begin
                        if (w_cand[N].found && w_late) begin
                            w_op.code   = OP_SEEN;
                            n_state     = S_SEARCH;
                            w_gen       = 1'b1;
                            w_res.pid   = w_cand[N].pid;
                            w_res.stime = w_cand[N].stime;
                            w_res.valid = 1'b1;
                        end
                    end
                    CMD_SENT: begin
                        w_gen = 1'b1;
                        if (w_cand[N].found) begin
                            w_op.code  = OP_WRITE;
                            w_op.pid   = r_pid;
                            w_op.stime = r_now;
                        end else begin
                            w_res.status = ST_FULL;
                        end
                    end
                    CMD_OLDEST: begin
                        if ((|(r_active & r_bit)) && w_cand[N].found &&
                            (!r_found || (w_cand[N].stime < r_old))) begin
                            n_old   = w_cand[N].stime;
                            n_found = 1'b1;
                        end
                        if (r_sc == SW'(S - 1)) begin
                            w_gen = 1'b1;
                            if (n_found) begin
                                w_res.stime = n_old;
                                w_res.valid = 1'b1;
                            end else begin
                                w_res.status = ST_NOMATCH;
                                w_res.stime  = TIME_ONES;
                            end
                        end else begin
                            n_sc    = r_sc + 1'b1;
                            n_bit   = r_bit << 1;
                            n_state = S_SEARCH;
                        end
                    end
                    default: ;
                endcase
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result holding: a result is sent once the next one, or the end, is known.
    always_comb begin
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_nres   = r_nres;
        n_strobe = 1'b0;
        n_last   = 1'b0;
        n_out    = r_out;
        if (r_state == S_FIN) begin
            n_strobe = 1'b1;
            n_last   = 1'b1;
            n_out    = r_hold_v ? r_hold : '0;
            n_hold_v = 1'b0;
            n_nres   = '0;
        end else if (w_gen && (r_nres < 5'(OUT_LIMIT))) begin
            if (r_hold_v) begin
                n_strobe = 1'b1;
                n_out    = r_hold;
            end
            n_hold   = w_res;
            n_hold_v = 1'b1;
            n_nres   = r_nres + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_active <= '0;
            r_hold_v <= 1'b0;
            r_nres   <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_mode   <= MD_FREE;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_active <= n_active;
            r_hold_v <= n_hold_v;
            r_nres   <= n_nres;
            r_strobe <= n_strobe;
            r_last   <= n_last;
            r_mode   <= n_mode;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_pid   <= n_pid;
        r_now   <= n_now;
        r_bit   <= n_bit;
        r_sc    <= n_sc;
        r_found <= n_found;
        r_old   <= n_old;
        r_hold  <= n_hold;
        r_out   <= n_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_last      = r_last;
    assign o_status    = r_out.status;
    assign o_out_pid   = r_out.pid;
    assign o_out_time  = r_out.stime;
    assign o_released  = r_out.released;
    assign o_valid_res = r_out.valid;

`include "assert_macros.svh"

    `MAT_ASSERT_NXT(a_start_busy, start && !busy, busy)
    `MAT_ASSERT_IMP(a_last_idle, o_strobe && o_last, r_state == S_IDLE)
    `MAT_ASSERT_IMP(a_mid_busy, o_strobe && !o_last, r_state != S_IDLE)

endmodule
